// ===== hw/rtl/upc_pkg.sv =====
// upc_pkg: shared types, character constants and helper functions
// of the url percent codec; no dependencies
`default_nettype none

package upc_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned JobBytes = 3;  // most bytes one input makes, terminator aside

  localparam logic [ByteW-1:0] ChrPercent = 8'h25;
  localparam logic [ByteW-1:0] ChrPlus    = 8'h2b;
  localparam logic [ByteW-1:0] ChrSpace   = 8'h20;
  localparam logic [ByteW-1:0] ChrMinus   = 8'h2d;
  localparam logic [ByteW-1:0] ChrUnder   = 8'h5f;
  localparam logic [ByteW-1:0] ChrDot     = 8'h2e;
  localparam logic [ByteW-1:0] ChrTilde   = 8'h7e;
  localparam logic [ByteW-1:0] ChrZero    = 8'h30;
  localparam logic [ByteW-1:0] ChrNine    = 8'h39;
  localparam logic [ByteW-1:0] ChrLowA    = 8'h61;
  localparam logic [ByteW-1:0] ChrLowZ    = 8'h7a;
  localparam logic [ByteW-1:0] ChrUpA     = 8'h41;
  localparam logic [ByteW-1:0] ChrUpZ     = 8'h5a;
  localparam logic [ByteW-1:0] CaseOffset = 8'h20;
  localparam logic [ByteW-1:0] Terminator = 8'h00;

  typedef struct packed {
    logic [ByteW-1:0] in_byte;
    logic             final_byte;
  } in_item_t;

  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic             run_end;
    logic             string_end;
  } out_item_t;

  // work handed from the front part to the back part for one input
  typedef struct packed {
    logic [JobBytes-1:0][ByteW-1:0] data;
    logic [1:0]                     n_bytes;  // 0..3 data bytes
    logic                           term;     // terminator follows
  } job_t;

  typedef enum logic [2:0] {
    PhIdle = 3'b001,
    PhPct  = 3'b010,
    PhHeld = 3'b100
  } phase_e;

  function automatic logic is_digit(input logic [ByteW-1:0] c);
    return (c >= ChrZero) && (c <= ChrNine);
  endfunction

  function automatic logic is_unreserved(input logic [ByteW-1:0] c);
    return is_digit(c) || ((c >= ChrLowA) && (c <= ChrLowZ)) ||
           ((c >= ChrUpA) && (c <= ChrUpZ)) ||
           (c == ChrMinus) || (c == ChrUnder) || (c == ChrDot) || (c == ChrTilde);
  endfunction

  // lowercase hex digit of a nibble
  function automatic logic [ByteW-1:0] hex_char(input logic [3:0] n);
    logic [ByteW-1:0] w;
    w = {4'd0, n};
    return (n < 4'd10) ? (ChrZero + w) : (ChrLowA + w - 8'd10);
  endfunction

  // unchecked digit value, wrapped to a byte
  function automatic logic [ByteW-1:0] nibble_of(input logic [ByteW-1:0] c);
    logic [ByteW-1:0] l;
    l = ((c >= ChrUpA) && (c <= ChrUpZ)) ? (c + CaseOffset) : c;
    return is_digit(c) ? (c - ChrZero) : (l - ChrLowA + 8'd10);
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/url_percent_codec_unit.sv =====
// url_percent_codec_unit: top level of the url percent encoder / decoder
// instantiates upc_front, upc_queue and upc_back; uses upc_pkg
// flow: an accepted input is written into the queue at the accepting edge;
//   its results are then loaded one by one from the queue head into the
//   output register
// throughput: one result per cycle from the back part while the output is not
//   stalled; one input makes 1 result for a plain byte, 3 for an escape,
//   plus 1 for the terminator; the front takes a byte every cycle while the
//   queue has room, and bytes that make no result are not queued
// reset: asynchronous active low; clears mode (encode), escape state, queue
//   and output valid; no clearing pass
`default_nettype none

module url_percent_codec_unit #(
  parameter int unsigned QueueDepth = 2  // jobs buffered between front and back
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  // configuration: decode_mode register
  input  wire                 cfg_we_i,
  input  wire                 cfg_wdata_i,
  // input channel
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  input  upc_pkg::in_item_t   in_item_i,
  // output channel
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  output upc_pkg::out_item_t  out_item_o
);

  logic           push, pop, q_full, q_empty;
  upc_pkg::job_t  job, head;

  // front: takes a transaction, tracks the escape, builds the job
  upc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_item_i  (in_item_i),
    .q_full_i   (q_full),
    .in_stall_o (in_stall_o),
    .push_o     (push),
    .job_o      (job)
  );

  // decouples the two sides so each can stall on its own
  upc_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(job),
    .pop_i      (pop),
    .full_o     (q_full),
    .empty_o    (q_empty),
    .head_o     (head)
  );

  // back: one output transaction per cycle from the head job while the output is not stalled
  upc_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (q_empty),
    .head_i     (head),
    .pop_o      (pop),
    .out_stall_i(out_stall_i),
    .out_valid_o(out_valid_o),
    .out_item_o (out_item_o)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/upc_front.sv =====
// upc_front: accepts input transactions, keeps the mode register and the
// escape state, and turns each byte into a job; uses upc_pkg
`default_nettype none

module upc_front (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 cfg_we_i,
  input  wire                 cfg_wdata_i,
  input  wire                 in_valid_i,
  input  upc_pkg::in_item_t   in_item_i,
  input  wire                 q_full_i,
  output logic                in_stall_o,
  output logic                push_o,
  output upc_pkg::job_t       job_o
);

  logic                       mode_q;
  upc_pkg::phase_e            phase_q, phase_d;
  logic [upc_pkg::ByteW-1:0]  held_q, held_d;
  logic                       accept;
  logic [upc_pkg::ByteW-1:0]  b;
  logic                       last;
  logic [upc_pkg::ByteW-1:0]  plain_byte;
  logic                       plain_pct;
  logic [upc_pkg::ByteW-1:0]  hi_val;
  logic [upc_pkg::ByteW-1:0]  lo_val;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign b          = in_item_i.in_byte;
  assign last       = in_item_i.final_byte;

  // ordinary decode of a byte with no escape pending
  assign plain_pct  = (b == upc_pkg::ChrPercent);
  assign plain_byte = (b == upc_pkg::ChrPlus) ? upc_pkg::ChrSpace : b;

  // unchecked digit values of the held byte and the current byte
  assign hi_val = upc_pkg::nibble_of(held_q);
  assign lo_val = upc_pkg::nibble_of(b);

  always_comb begin
    job_o   = '0;
    phase_d = phase_q;
    held_d  = held_q;
    if (accept) begin
      if (!mode_q) begin
        phase_d = upc_pkg::PhIdle;
        held_d  = '0;
        if (upc_pkg::is_unreserved(b)) begin
          job_o.data[0] = b;
          job_o.n_bytes = 2'd1;
        end else if (b == upc_pkg::ChrSpace) begin
          job_o.data[0] = upc_pkg::ChrPlus;
          job_o.n_bytes = 2'd1;
        end else begin
          job_o.data[0] = upc_pkg::ChrPercent;
          job_o.data[1] = upc_pkg::hex_char(b[7:4]);
          job_o.data[2] = upc_pkg::hex_char(b[3:0]);
          job_o.n_bytes = 2'd3;
        end
      end else begin
        case (phase_q)
          upc_pkg::PhPct: begin
            if (last) begin
              // string ends after percent and one byte: percent dropped
              phase_d = upc_pkg::PhIdle;
              if (!plain_pct) begin
                job_o.data[0] = plain_byte;
                job_o.n_bytes = 2'd1;
              end
            end else begin
              held_d  = b;
              phase_d = upc_pkg::PhHeld;
            end
          end
          upc_pkg::PhHeld: begin
            job_o.data[0] = {hi_val[3:0], 4'd0} | lo_val;
            job_o.n_bytes = 2'd1;
            phase_d       = upc_pkg::PhIdle;
          end
          default: begin
            if (plain_pct) begin
              phase_d = last ? upc_pkg::PhIdle : upc_pkg::PhPct;
            end else begin
              job_o.data[0] = plain_byte;
              job_o.n_bytes = 2'd1;
              phase_d       = upc_pkg::PhIdle;
            end
          end
        endcase
      end
      if (last) begin
        job_o.term = 1'b1;
        phase_d    = upc_pkg::PhIdle;
      end
    end
  end

  assign push_o = accept && ((job_o.n_bytes != 2'd0) || job_o.term);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= 1'b0;
      phase_q <= upc_pkg::PhIdle;
      held_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
      phase_q <= phase_d;
      held_q  <= held_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/upc_queue.sv =====
// upc_queue: short first-in first-out queue of jobs between the front and
// the back part; uses upc_pkg
`default_nettype none

module upc_queue #(
  parameter int unsigned Depth = 2
) (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            push_i,
  input  upc_pkg::job_t  push_data_i,
  input  wire            pop_i,
  output logic           full_o,
  output logic           empty_o,
  output upc_pkg::job_t  head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  upc_pkg::job_t    entries_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = entries_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/upc_back.sv =====
// upc_back: plays out the bytes of each queued job one per cycle, while the
// output is not stalled, into the output register; uses upc_pkg
`default_nettype none

module upc_back (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 q_empty_i,
  input  upc_pkg::job_t       head_i,
  output logic                pop_o,
  input  wire                 out_stall_i,
  output logic                out_valid_o,
  output upc_pkg::out_item_t  out_item_o
);

  logic [1:0]                idx_q;
  logic                      out_valid_q;
  upc_pkg::out_item_t        out_q, out_d;
  logic                      advance, emit, is_term, is_last;
  logic [2:0]                total;

  assign advance = !out_valid_q || !out_stall_i;
  assign emit    = advance && !q_empty_i;
  assign total   = {1'b0, head_i.n_bytes} + {2'd0, head_i.term};
  assign is_term = (idx_q >= head_i.n_bytes);
  assign is_last = (({1'b0, idx_q} + 3'd1) == total);
  assign pop_o   = emit && is_last;

  always_comb begin
    out_d.run_end    = is_last;
    out_d.string_end = is_term;
    case (idx_q)
      2'd0:    out_d.out_byte = head_i.data[0];
      2'd1:    out_d.out_byte = head_i.data[1];
      2'd2:    out_d.out_byte = head_i.data[2];
      default: out_d.out_byte = upc_pkg::Terminator;
    endcase
    if (is_term) begin
      out_d.out_byte = upc_pkg::Terminator;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else if (advance) begin
      out_valid_q <= !q_empty_i;
      if (emit) begin
        idx_q <= is_last ? 2'd0 : idx_q + 2'd1;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

// ===== tb/url_percent_codec_checker.sv =====
// url_percent_codec_checker: watches both channels of url_percent_codec_unit,
// predicts its output transactions and compares them field by field
// depends on upc_pkg for the item types, phase enum and character constants

module url_percent_codec_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_wdata_i,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  upc_pkg::in_item_t  in_item_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  upc_pkg::out_item_t out_item_i,
  output int                 mismatch_count_o,
  output int                 pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import upc_pkg::*;

  localparam logic [16*ByteW-1:0] HexDigits   = "0123456789abcdef";
  localparam int unsigned         ReportLimit = 10;

  logic             decode_mode_q;
  phase_e           phase_q;
  logic [ByteW-1:0] held_char_q;
  logic [ByteW-1:0] made_bytes[$];
  out_item_t        expected_out_q[$];
  out_item_t        oldest_expected;

  function automatic logic [ByteW-1:0] digit_value(input logic [ByteW-1:0] c);
    if (c >= ChrZero && c <= ChrNine) return c - ChrZero;
    if (c >= ChrUpA && c <= ChrUpZ) return c - ChrUpA + 8'd10;
    return c - ChrLowA + 8'd10;
  endfunction

  function automatic logic [ByteW-1:0] hex_digit(input logic [3:0] n);
    return HexDigits[(15 - int'(n)) * ByteW +: ByteW];
  endfunction

  function automatic logic passes_unescaped(input logic [ByteW-1:0] c);
    return (c >= ChrZero && c <= ChrNine) || (c >= ChrLowA && c <= ChrLowZ) ||
           (c >= ChrUpA && c <= ChrUpZ) || c == ChrMinus || c == ChrUnder ||
           c == ChrDot || c == ChrTilde;
  endfunction

  // decode of a byte with no escape open
  task automatic decode_plain(input logic [ByteW-1:0] b, input logic last);
    if (b == ChrPercent) begin
      phase_q = last ? PhIdle : PhPct;
    end else begin
      made_bytes.push_back((b == ChrPlus) ? ChrSpace : b);
    end
  endtask

  task automatic predict_codec_step(input in_item_t item);
    logic [ByteW-1:0] b;
    out_item_t        r;
    int               n;
    b = item.in_byte;
    made_bytes.delete();
    if (!decode_mode_q) begin
      phase_q     = PhIdle;
      held_char_q = '0;
      if (passes_unescaped(b)) begin
        made_bytes.push_back(b);
      end else if (b == ChrSpace) begin
        made_bytes.push_back(ChrPlus);
      end else begin
        made_bytes.push_back(ChrPercent);
        made_bytes.push_back(hex_digit(b[7:4]));
        made_bytes.push_back(hex_digit(b[3:0]));
      end
    end else if (phase_q == PhPct) begin
      if (item.final_byte) begin
        phase_q = PhIdle;
        decode_plain(b, 1'b1);
      end else begin
        held_char_q = b;
        phase_q     = PhHeld;
      end
    end else if (phase_q == PhHeld) begin
      phase_q = PhIdle;
      made_bytes.push_back((digit_value(held_char_q) << 4) | digit_value(b));
    end else begin
      phase_q = PhIdle;
      decode_plain(b, item.final_byte);
    end
    if (item.final_byte) phase_q = PhIdle;

    n = made_bytes.size() + (item.final_byte ? 1 : 0);
    for (int i = 0; i < made_bytes.size(); i++) begin
      r.out_byte   = made_bytes[i];
      r.run_end    = (i == n - 1);
      r.string_end = 1'b0;
      expected_out_q.push_back(r);
    end
    if (item.final_byte) begin
      r.out_byte   = Terminator;
      r.run_end    = 1'b1;
      r.string_end = 1'b1;
      expected_out_q.push_back(r);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decode_mode_q    = 1'b0;
      phase_q          = PhIdle;
      held_char_q      = '0;
      expected_out_q.delete();
      mismatch_count_o = 0;
      pending_o        = 0;
    end else begin
      if (cfg_we_i) decode_mode_q = cfg_wdata_i;
      // an output accepted now never stems from an input accepted at the same edge
      if (out_valid_i && !out_stall_i) begin
        if (expected_out_q.size() == 0) begin
          mismatch_count_o++;
          if (mismatch_count_o <= ReportLimit)
            $display("unexpected output: byte %h run_end %b string_end %b",
                     out_item_i.out_byte, out_item_i.run_end, out_item_i.string_end);
        end else begin
          oldest_expected = expected_out_q.pop_front();
          if (out_item_i.out_byte !== oldest_expected.out_byte ||
              out_item_i.run_end !== oldest_expected.run_end ||
              out_item_i.string_end !== oldest_expected.string_end) begin
            mismatch_count_o++;
            if (mismatch_count_o <= ReportLimit)
              $display("output mismatch: expected byte %h run_end %b string_end %b, %s",
                       oldest_expected.out_byte, oldest_expected.run_end,
                       oldest_expected.string_end,
                       $sformatf("got byte %h run_end %b string_end %b",
                                 out_item_i.out_byte, out_item_i.run_end,
                                 out_item_i.string_end));
          end
        end
      end
      if (in_valid_i && !in_stall_i) predict_codec_step(in_item_i);
      pending_o = expected_out_q.size();
    end
  end

endmodule

// ===== tb/url_percent_codec_unit_tb.sv =====
// url_percent_codec_unit_tb: stimulus and verdict for url_percent_codec_unit
// depends on upc_pkg, the block itself and url_percent_codec_checker

module url_percent_codec_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import upc_pkg::*;

  localparam int unsigned CycleLimit  = 400000;  // far above the slowest legal run
  localparam int unsigned QuietCycles = 8;       // quiet margin after each drain, in cycles
  localparam int unsigned LongHold    = 150;     // receiver hold-off, in cycles
  localparam int unsigned PhaseItems  = 35;      // minimum input transactions per random phase
  localparam int unsigned RandPhases  = 8;
  localparam logic        ModeEncode  = 1'b0;
  localparam logic        ModeDecode  = 1'b1;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we;
  logic        cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_item;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_item;
  int          mismatch_count;
  int          pending_count;
  int unsigned cycle_count;
  int unsigned items_sent;

  // pacing knobs shared between the sender and the receiver
  bit tx_no_gap = 1'b0;
  bit rx_no_gap = 1'b0;
  bit hold_req  = 1'b0;

  url_percent_codec_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  url_percent_codec_checker codec_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .in_item_i        (in_item),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .out_item_i       (out_item),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending_count)
  );

  initial begin : clock_gen
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // hard stop in case the block hangs
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("status: fail");
    $finish;
  end

  // receiver: random stall before each output transaction, plus one long hold-off
  initial begin : result_sink
    int unsigned stall_cycles;
    int unsigned hold_n;
    out_stall = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        // stall long enough for the internal queue to fill and back up the input
        out_stall = 1'b1;
        for (hold_n = 0; hold_n < LongHold; hold_n++) @(negedge clk_i);
        hold_req = 1'b0;
      end
      stall_cycles = rx_no_gap ? 0 : $urandom_range(10);
      if (stall_cycles != 0) begin
        out_stall = 1'b1;
        repeat (stall_cycles) @(negedge clk_i);
      end
      out_stall = 1'b0;
      // accepted at the first rising edge that sees valid with stall low
      do @(posedge clk_i); while (!out_valid);
    end
  end

  // --- sender side -------------------------------------------------------

  // one input transaction; called and returns at a falling edge
  // valid stays high on return so back-to-back items never drop it
  task automatic send_item(input logic [ByteW-1:0] b, input logic last);
    int unsigned gap;
    gap = tx_no_gap ? 0 : $urandom_range(10);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_item.in_byte    = b;
    in_item.final_byte = last;
    in_valid           = 1'b1;
    do @(posedge clk_i); while (in_stall);
    @(negedge clk_i);
    items_sent++;
  endtask

  // stop offering and wait for every predicted output, then some quiet cycles
  task automatic wait_drain(input int unsigned extra);
    in_valid = 1'b0;
    while (pending_count != 0) @(negedge clk_i);
    repeat (extra) @(negedge clk_i);
  endtask

  // single-register config write; only called with the block idle
  task automatic write_mode(input logic m);
    cfg_wdata = m;
    cfg_we    = 1'b1;
    @(negedge clk_i);
    cfg_we    = 1'b0;
  endtask

  function automatic logic [ByteW-1:0] rand_unreserved();
    int unsigned r;
    r = $urandom_range(65);
    if (r < 10) return ChrZero + 8'(r);
    if (r < 36) return ChrLowA + 8'(r - 10);
    if (r < 62) return ChrUpA + 8'(r - 36);
    if (r == 62) return ChrMinus;
    if (r == 63) return ChrUnder;
    if (r == 64) return ChrDot;
    return ChrTilde;
  endfunction

  // hex digit in either case, as a well-formed escape would carry it
  function automatic logic [ByteW-1:0] rand_hex_char();
    logic [3:0] n;
    n = 4'($urandom_range(15));
    if (n < 4'd10) return ChrZero + 8'(n);
    return ($urandom_range(1) ? ChrUpA : ChrLowA) + 8'(n) - 8'd10;
  endfunction

  function automatic logic [ByteW-1:0] rand_any_byte();
    return 8'($urandom_range(1, 255));
  endfunction

  // a byte that does not open an escape
  function automatic logic [ByteW-1:0] rand_plain_byte();
    logic [ByteW-1:0] b;
    if ($urandom_range(1)) return rand_unreserved();
    do b = rand_any_byte(); while (b == ChrPercent);
    return b;
  endfunction

  task automatic send_encode_string();
    logic [ByteW-1:0] text[$];
    int unsigned      len;
    int unsigned      pick;
    len = $urandom_range(1, 8);
    repeat (len) begin
      pick = $urandom_range(99);
      if (pick < 50)      text.push_back(rand_unreserved());
      else if (pick < 65) text.push_back(ChrSpace);
      else                text.push_back(rand_any_byte());
    end
    foreach (text[i]) send_item(text[i], i == text.size() - 1);
  endtask

  // mostly well-formed escapes and plain bytes, with some noise and broken endings
  task automatic send_decode_string();
    logic [ByteW-1:0] text[$];
    int unsigned      tokens;
    int unsigned      pick;
    tokens = $urandom_range(1, 6);
    repeat (tokens) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        text.push_back(rand_plain_byte());
      end else if (pick < 75) begin
        text.push_back(ChrPercent);
        text.push_back(rand_hex_char());
        text.push_back(rand_hex_char());
      end else if (pick < 85) begin
        text.push_back(ChrPlus);
      end else if (pick < 92) begin
        // escape with unchecked, possibly non-hex, digits
        text.push_back(ChrPercent);
        text.push_back(rand_any_byte());
        text.push_back(rand_any_byte());
      end else begin
        text.push_back(rand_any_byte());
      end
    end
    // string cut short right after the percent or after its first digit
    pick = $urandom_range(9);
    if (pick == 0) begin
      text.push_back(ChrPercent);
    end else if (pick == 1) begin
      text.push_back(ChrPercent);
      text.push_back($urandom_range(3) == 0 ? rand_any_byte() : rand_hex_char());
    end
    foreach (text[i]) send_item(text[i], i == text.size() - 1);
  endtask

  initial begin : stimulus
    int unsigned p;
    logic        mode;
    bit          paused;
    in_valid   = 1'b0;
    in_item    = '0;
    cfg_we     = 1'b0;
    cfg_wdata  = ModeEncode;
    rst_ni     = 1'b0;
    items_sent = 0;
    paused     = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed encode: every unescaped class, space, top byte, zero byte
    write_mode(ModeEncode);
    send_item("A", 1'b0);
    send_item("z", 1'b0);
    send_item("9", 1'b0);
    send_item(ChrMinus, 1'b0);
    send_item(ChrUnder, 1'b0);
    send_item(ChrDot, 1'b0);
    send_item(ChrTilde, 1'b0);
    send_item(ChrSpace, 1'b0);
    send_item(8'hff, 1'b0);
    send_item(8'h00, 1'b1);
    wait_drain(QuietCycles);

    // directed decode: plus, escapes in both cases, non-hex escape, zero byte
    write_mode(ModeDecode);
    send_item(ChrPlus, 1'b0);
    send_item(ChrPercent, 1'b0);
    send_item("4", 1'b0);
    send_item("1", 1'b0);
    send_item(ChrPercent, 1'b0);
    send_item("F", 1'b0);
    send_item("f", 1'b0);
    send_item(ChrPercent, 1'b0);
    send_item("z", 1'b0);
    send_item("Z", 1'b0);
    send_item(8'h00, 1'b1);
    // percent as the last byte is dropped
    send_item(ChrPercent, 1'b1);
    // percent then a held plus at the end: plus turns into a space
    send_item(ChrPercent, 1'b0);
    send_item(ChrPlus, 1'b1);
    // percent then a held percent at the end: both dropped
    send_item(ChrPercent, 1'b0);
    send_item(ChrPercent, 1'b1);

    // random phases alternate the mode; some run flat out, one backs up the block
    for (p = 0; p < RandPhases; p++) begin
      mode = (p % 2 == 0) ? ModeEncode : ModeDecode;
      wait_drain(QuietCycles);
      write_mode(mode);
      tx_no_gap  = (p == 2) || (p == 5);
      rx_no_gap  = (p == 5);
      items_sent = 0;
      if (p == 2) hold_req = 1'b1;
      while (items_sent < PhaseItems) begin
        // sender pauses mid-phase until every output has come back
        if (p == 6 && !paused && items_sent >= PhaseItems / 2) begin
          wait_drain(0);
          paused = 1'b1;
        end
        if (mode == ModeDecode) send_decode_string();
        else                    send_encode_string();
      end
      // leave an escape open so the next mode change abandons it
      if (mode == ModeDecode && $urandom_range(1)) begin
        send_item(ChrPercent, 1'b0);
        if ($urandom_range(1)) send_item(rand_hex_char(), 1'b0);
      end
    end
    tx_no_gap = 1'b0;
    rx_no_gap = 1'b0;

    wait_drain(20);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
